[rtl/tlex_pkg.sv]
// Shared types, character codes and keyword table for the token scanner.
`timescale 1ns / 1ps

package tlex_pkg;

  localparam int KwCount    = 8;
  localparam int KwMaxLen   = 6;
  localparam int QueueDepth = 4;

  typedef enum logic [3:0] {
    CLS_RESERVED = 4'd0,
    CLS_NUMBER   = 4'd1,
    CLS_IDENT    = 4'd2,
    CLS_PLUS     = 4'd3,
    CLS_MINUS    = 4'd4,
    CLS_MUL      = 4'd5,
    CLS_DIV      = 4'd6,
    CLS_EQUAL    = 4'd7,
    CLS_BRACKET  = 4'd8,
    CLS_SEMI     = 4'd9,
    CLS_ASSIGN   = 4'd10,
    CLS_UNKNOWN  = 4'd11
  } tok_class_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_EQ    = 2'd1,
    PEND_COLON = 2'd2
  } pend_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } tlex_in_t;

  typedef struct packed {
    tok_class_e  token_class;
    logic [31:0] token_start;
    logic [7:0]  token_length;
    logic        last_of_run;
  } tlex_out_t;

  // All tokens caused by one character; first is always valid.
  typedef struct packed {
    logic      two;
    tlex_out_t second;
    tlex_out_t first;
  } tlex_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tlex_q_status_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // Keywords are right-justified: the last character sits in the low byte.
  localparam logic [8*KwMaxLen-1:0] KW_TEXT [KwCount] = '{
    48'("if"), 48'("then"), 48'("else"), 48'("end"),
    48'("repeat"), 48'("until"), 48'("read"), 48'("write")
  };
  localparam logic [7:0] KW_LEN [KwCount] = '{
    8'd2, 8'd4, 8'd4, 8'd3, 8'd6, 8'd5, 8'd4, 8'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic tok_class_e sym_class(input logic [7:0] c);
    tok_class_e cls;
    unique case (c)
      CH_PLUS:              cls = CLS_PLUS;
      CH_MINUS:             cls = CLS_MINUS;
      CH_STAR:              cls = CLS_MUL;
      CH_SLASH:             cls = CLS_DIV;
      CH_LPAREN, CH_RPAREN: cls = CLS_BRACKET;
      CH_SEMI:              cls = CLS_SEMI;
      default:              cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

  // All eight keyword compares run in parallel; head[0] is the first character.
  function automatic logic kw_match(input logic [KwMaxLen-1:0][7:0] head,
                                    input logic [7:0] len);
    logic [8*KwMaxLen-1:0] cand;
    logic                  hit;
    hit = 1'b0;
    for (int i = 0; i < KwCount; i++) begin
      cand = '0;
      for (int j = 0; j < KwMaxLen; j++) begin
        if (8'(j) < KW_LEN[i]) begin
          cand = {cand[8*KwMaxLen-9:0], head[j]};
        end
      end
      if ((len == KW_LEN[i]) && (cand == KW_TEXT[i])) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

[rtl/tlex_front.sv]
// Front end: scans one character per beat and builds the tokens it finishes.
`timescale 1ns / 1ps

module tlex_front #(
  parameter int KEYWORD_CHARS = 6,
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tlex_pkg::tlex_in_t      in_i,
  input  tlex_pkg::tlex_q_status_t q_status_i,
  output logic                    push_o,
  output tlex_pkg::tlex_rec_t     rec_o
);
  import tlex_pkg::*;

  localparam int HeadIdxW = $clog2(KEYWORD_CHARS);
  localparam int StartW   = (POSITION_BITS < 32) ? POSITION_BITS : 32;

  logic                     in_word_q, in_word_d;
  logic                     digit_q, digit_d;
  logic [7:0]               len_q, len_d;
  logic [StartW-1:0]        start_q, start_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  pend_e                    pend_q, pend_d;
  logic [7:0]               head_q [KEYWORD_CHARS];

  logic                     accept;
  logic [7:0]               c;
  logic                     last;
  logic                     pend_valid, pair, alnum, alnum_path, other_path;
  logic [StartW-1:0]        pos_s;
  logic                     in_word_m, digit_m;
  logic [7:0]               len_base, len_m;
  logic [StartW-1:0]        start_a;
  logic                     wr_head;
  logic [KwMaxLen-1:0][7:0] head_view;
  logic                     flush_word;
  tok_class_e               word_cls;
  logic                     pend_set_eq, pend_set_col, sym_emit;
  logic [4:0]               ev_v;
  tlex_out_t                ev_tok [5];
  logic                     have0;

  assign accept     = in_valid_i && !q_status_i.full;
  assign in_stall_o = q_status_i.full;

  always_comb begin
    c          = in_i.char_code;
    last       = in_i.end_of_text;
    pend_valid = (pend_q == PEND_EQ) || (pend_q == PEND_COLON);
    pair       = pend_valid && (c == CH_EQUAL);
    alnum      = is_digit(c) || is_alpha(c);
    alnum_path = !pair && alnum;
    other_path = !pair && !alnum;
    pos_s      = pos_q[StartW-1:0];

    // Word state after this character, before any flush.
    in_word_m = in_word_q || alnum_path;
    digit_m   = (alnum_path && !in_word_q) ? is_digit(c) : digit_q;
    start_a   = (alnum_path && !in_word_q) ? pos_s : start_q;
    len_base  = in_word_q ? len_q : 8'd0;
    if (alnum_path) begin
      len_m = (len_base == 8'd255) ? 8'd255 : len_base + 8'd1;
    end else begin
      len_m = len_q;
    end
    wr_head = alnum_path && (len_base < 8'(KEYWORD_CHARS));
    for (int j = 0; j < KwMaxLen; j++) begin
      head_view[j] = (wr_head && (len_base == 8'(j))) ? c : head_q[j];
    end

    flush_word = in_word_m && (other_path || last);
    if (digit_m) begin
      word_cls = CLS_NUMBER;
    end else if (kw_match(head_view, len_m)) begin
      word_cls = CLS_RESERVED;
    end else begin
      word_cls = CLS_IDENT;
    end

    pend_set_eq  = other_path && (c == CH_EQUAL);
    pend_set_col = other_path && (c == CH_COLON);
    sym_emit     = other_path && !is_sep(c) && (c != CH_EQUAL) && (c != CH_COLON);

    // Candidate tokens in the order they leave the block.
    ev_v[0] = pair;
    ev_tok[0].token_class  = (pend_q == PEND_EQ) ? CLS_EQUAL : CLS_ASSIGN;
    ev_tok[0].token_start  = 32'(start_q);
    ev_tok[0].token_length = 8'd2;
    ev_tok[0].last_of_run  = 1'b0;

    ev_v[1] = !pair && pend_valid;
    ev_tok[1].token_class  = CLS_UNKNOWN;
    ev_tok[1].token_start  = 32'(start_q);
    ev_tok[1].token_length = 8'd1;
    ev_tok[1].last_of_run  = 1'b0;

    ev_v[2] = flush_word;
    ev_tok[2].token_class  = word_cls;
    ev_tok[2].token_start  = 32'(start_a);
    ev_tok[2].token_length = len_m;
    ev_tok[2].last_of_run  = 1'b0;

    ev_v[3] = sym_emit;
    ev_tok[3].token_class  = sym_class(c);
    ev_tok[3].token_start  = 32'(pos_s);
    ev_tok[3].token_length = 8'd1;
    ev_tok[3].last_of_run  = 1'b0;

    // A lone '=' or ':' on the last character is flushed at once.
    ev_v[4] = last && (pend_set_eq || pend_set_col);
    ev_tok[4].token_class  = CLS_UNKNOWN;
    ev_tok[4].token_start  = 32'(pos_s);
    ev_tok[4].token_length = 8'd1;
    ev_tok[4].last_of_run  = 1'b0;

    // At most two candidates fire for any character.
    have0 = 1'b0;
    rec_o = '0;
    for (int i = 0; i < 5; i++) begin
      if (ev_v[i]) begin
        if (!have0) begin
          rec_o.first = ev_tok[i];
          have0       = 1'b1;
        end else begin
          rec_o.second = ev_tok[i];
          rec_o.two    = 1'b1;
        end
      end
    end
    rec_o.first.last_of_run  = !rec_o.two;
    rec_o.second.last_of_run = 1'b1;

    push_o = accept && (ev_v != 5'd0);

    in_word_d = in_word_m && !flush_word;
    digit_d   = flush_word ? 1'b0 : digit_m;
    len_d     = flush_word ? 8'd0 : len_m;
    start_d   = (pend_set_eq || pend_set_col) ? pos_s : start_a;
    if (last) begin
      pend_d = PEND_NONE;
    end else if (pend_set_eq) begin
      pend_d = PEND_EQ;
    end else if (pend_set_col) begin
      pend_d = PEND_COLON;
    end else begin
      pend_d = PEND_NONE;
    end
    pos_d = pos_q + POSITION_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      digit_q   <= 1'b0;
      len_q     <= 8'd0;
      start_q   <= '0;
      pos_q     <= '0;
      pend_q    <= PEND_NONE;
    end else if (accept) begin
      in_word_q <= in_word_d;
      digit_q   <= digit_d;
      len_q     <= len_d;
      start_q   <= start_d;
      pos_q     <= pos_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_head) begin
      head_q[len_base[HeadIdxW-1:0]] <= c;
    end
  end

endmodule

[rtl/tlex_queue.sv]
// Small record queue that decouples the scanner from the output stage.
`timescale 1ns / 1ps

module tlex_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  tlex_pkg::tlex_rec_t      rec_i,
  input  logic                     pop_i,
  output tlex_pkg::tlex_q_status_t status_o,
  output tlex_pkg::tlex_rec_t      rec_o
);
  import tlex_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  tlex_rec_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  always_comb begin
    status_o.full  = (count_q == (PtrW + 1)'(QueueDepth));
    status_o.empty = (count_q == '0);
    rec_o          = mem_q[rd_ptr_q];
    wr_ptr_d       = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d       = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + (PtrW + 1)'(1);
      2'b01:   count_d = count_q - (PtrW + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

[rtl/tlex_back.sv]
// Back end: unpacks queued records into one token beat per cycle while the receiver does not stall.
`timescale 1ns / 1ps

module tlex_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tlex_pkg::tlex_q_status_t q_status_i,
  input  tlex_pkg::tlex_rec_t      q_rec_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tlex_pkg::tlex_out_t      out_o
);
  import tlex_pkg::*;

  logic      cur_v_q;
  logic      second_q;
  tlex_rec_t cur_q;
  logic      out_acc, finish, advance;

  assign out_valid_o = cur_v_q;
  assign out_o       = second_q ? cur_q.second : cur_q.first;
  assign out_acc     = cur_v_q && !out_stall_i;
  assign finish      = out_acc && (second_q || !cur_q.two);
  assign advance     = out_acc && !finish;
  assign pop_o       = !q_status_i.empty && (!cur_v_q || finish);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (pop_o) begin
      cur_v_q  <= 1'b1;
      second_q <= 1'b0;
    end else if (finish) begin
      cur_v_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (advance) begin
      second_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_rec_i;
    end
  end

endmodule

[rtl/tiny_lexer_token_classifier_unit.sv]
// Top level of the streaming token scanner.
`timescale 1ns / 1ps

// Usage:
//   The input channel takes one source character per beat (char_code plus an
//   end_of_text flag). The output channel gives one token per beat: class,
//   start offset, length, and last_of_run on the final token a character caused.
//   A character finishes zero, one or two tokens.
//   A token is written into the queue when the character that finishes it is
//   accepted, then popped into the output register, from which it leaves; the
//   second token of a pair follows from the same register once the first is taken.
//   Throughput: one character per cycle while the queue is not full. The scanner,
//   including the parallel keyword compare, takes a new character while earlier
//   tokens wait; the output stage moves one token per cycle while the receiver
//   does not stall, and a four-record queue between the two halves absorbs pairs.
//   When the receiver stalls, the held token stays unchanged; the scanner keeps
//   taking characters until the queue is full, then stalls its input.
//   Reset clears the word state, any pending '=' or ':', the queue and the
//   position counter; the first character after reset has offset zero.
//   The end_of_text flag flushes the pending token; offsets keep counting.
module tiny_lexer_token_classifier_unit #(
  parameter int KEYWORD_CHARS = 6,
  parameter int POSITION_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlex_pkg::tlex_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlex_pkg::tlex_out_t out_o
);
  import tlex_pkg::*;

  logic           push, pop;
  tlex_rec_t      push_rec, pop_rec;
  tlex_q_status_t q_status;

  tlex_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_i      (in_i),
    .q_status_i(q_status),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  tlex_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .status_o(q_status),
    .rec_o   (pop_rec)
  );

  tlex_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_rec_i    (pop_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("record pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("record popped from an empty queue");

  a_pair_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_o.last_of_run) |=> out_valid_o)
    else $error("second token of a pair did not follow");
`endif

endmodule

[test/tlex_token_checker.sv]
// Checker that predicts the scanner's tokens from the input beats and compares them.
`timescale 1ns / 1ps

module tlex_token_checker
  import tlex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  tlex_in_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  tlex_out_t out_beat_i,
  output int        fail_count_o,
  output int        outstanding_o,
  output int        tokens_checked_o
);

  // Scanner state as the predictor sees it.
  logic        in_word;
  logic        word_from_digit;
  logic [7:0]  word_len;
  logic [31:0] token_origin;
  logic [31:0] char_pos;
  logic [7:0]  head_buf [6];
  pend_e       pend_sym;

  tlex_out_t tokens_due [$];
  int        mismatches;
  int        checked;

  function automatic logic char_is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic char_is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic word_is_keyword();
    logic [47:0] acc;
    acc = '0;
    if (word_len > 8'd6) return 1'b0;
    for (int j = 0; j < int'(word_len); j++) begin
      acc = {acc[39:0], head_buf[j]};
    end
    // Keyword characters are never zero, so the zero fill also checks the length.
    case (acc)
      "if", "then", "else", "end", "repeat", "until", "read", "write": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_token(input tok_class_e cls, input logic [31:0] start,
                                     input logic [7:0] len);
    tlex_out_t tok;
    tok.token_class  = cls;
    tok.token_start  = start;
    tok.token_length = len;
    tok.last_of_run  = 1'b0;
    tokens_due.push_back(tok);
  endfunction

  function automatic void close_word();
    tok_class_e cls;
    if (!in_word) return;
    if (word_from_digit) cls = CLS_NUMBER;
    else if (word_is_keyword()) cls = CLS_RESERVED;
    else cls = CLS_IDENT;
    push_token(cls, token_origin, word_len);
    in_word         = 1'b0;
    word_from_digit = 1'b0;
    word_len        = '0;
  endfunction

  function automatic void drop_pending_symbol();
    if (pend_sym == PEND_EQ || pend_sym == PEND_COLON) begin
      push_token(CLS_UNKNOWN, token_origin, 8'd1);
    end
    pend_sym = PEND_NONE;
  endfunction

  function automatic void scan_char(input tlex_in_t beat);
    logic [7:0] c;
    int         due_before;
    tok_class_e cls;
    c = beat.char_code;
    due_before = tokens_due.size();
    if (pend_sym == PEND_EQ && c == CH_EQUAL) begin
      push_token(CLS_EQUAL, token_origin, 8'd2);
      pend_sym = PEND_NONE;
    end else if (pend_sym == PEND_COLON && c == CH_EQUAL) begin
      push_token(CLS_ASSIGN, token_origin, 8'd2);
      pend_sym = PEND_NONE;
    end else begin
      drop_pending_symbol();
      if (char_is_alnum(c)) begin
        if (!in_word) begin
          in_word         = 1'b1;
          word_from_digit = char_is_digit(c);
          word_len        = '0;
          token_origin    = char_pos;
        end
        if (word_len < 8'd6) head_buf[word_len] = c;
        if (word_len != 8'd255) word_len = word_len + 8'd1;
      end else begin
        close_word();
        if (c == CH_EQUAL) begin
          pend_sym     = PEND_EQ;
          token_origin = char_pos;
        end else if (c == CH_COLON) begin
          pend_sym     = PEND_COLON;
          token_origin = char_pos;
        end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
          case (c)
            CH_PLUS:              cls = CLS_PLUS;
            CH_MINUS:             cls = CLS_MINUS;
            CH_STAR:              cls = CLS_MUL;
            CH_SLASH:             cls = CLS_DIV;
            CH_LPAREN, CH_RPAREN: cls = CLS_BRACKET;
            CH_SEMI:              cls = CLS_SEMI;
            default:              cls = CLS_UNKNOWN;
          endcase
          push_token(cls, char_pos, 8'd1);
        end
      end
    end
    if (beat.end_of_text) begin
      drop_pending_symbol();
      close_word();
    end
    char_pos = char_pos + 32'd1;
    if (tokens_due.size() > due_before) begin
      tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  function automatic void check_token(input tlex_out_t got);
    tlex_out_t want;
    if (tokens_due.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: unexpected token: class %0d start %0d len %0d last %0b", $realtime,
                 got.token_class, got.token_start, got.token_length, got.last_of_run);
      end
      mismatches++;
      return;
    end
    want = tokens_due.pop_front();
    checked++;
    if (got.token_class !== want.token_class || got.token_start !== want.token_start ||
        got.token_length !== want.token_length || got.last_of_run !== want.last_of_run) begin
      if (mismatches < 10) begin
        $display("%0t: token differs: expected class %0d start %0d len %0d last %0b",
                 $realtime, want.token_class, want.token_start, want.token_length,
                 want.last_of_run);
        $display("%0t:                got class %0d start %0d len %0d last %0b",
                 $realtime, got.token_class, got.token_start, got.token_length,
                 got.last_of_run);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word         = 1'b0;
      word_from_digit = 1'b0;
      word_len        = '0;
      token_origin    = '0;
      char_pos        = '0;
      pend_sym        = PEND_NONE;
      for (int k = 0; k < 6; k++) head_buf[k] = '0;
      tokens_due.delete();
    end else begin
      // A token never leaves in the cycle of the beat that causes it.
      if (out_valid_i && !out_stall_i) check_token(out_beat_i);
      if (in_valid_i && !in_stall_i) scan_char(in_beat_i);
    end
    fail_count_o     <= mismatches;
    outstanding_o    <= tokens_due.size();
    tokens_checked_o <= checked;
  end

endmodule

[test/tb_tiny_lexer_token_classifier_unit.sv]
// Testbench top: drives source text into the token scanner and gives the verdict.
`timescale 1ns / 1ps

module tb_tiny_lexer_token_classifier_unit;
  import tlex_pkg::*;

  localparam int RandomChars = 110;
  localparam int LongWordLen = 270;
  localparam int LongHoldCycles = 200;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  tlex_in_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  tlex_out_t out_o;

  int chk_fails;
  int outstanding;
  int tokens_checked;

  int   chars_sent    = 0;
  int   tokens_taken  = 0;
  logic fast_send     = 1'b0;
  logic fast_recv     = 1'b0;
  logic long_hold_req = 1'b0;
  int   long_holds    = 0;

  logic [7:0] piece_q [$];
  string      kw_words [8] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tiny_lexer_token_classifier_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  tlex_token_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_beat_i        (in_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_beat_i       (out_o),
    .fail_count_o     (chk_fails),
    .outstanding_o    (outstanding),
    .tokens_checked_o (tokens_checked)
  );

  task automatic offer_char(input logic [7:0] code, input logic eot);
    int gap;
    gap = fast_send ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= '{char_code: code, end_of_text: eot};
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    if (chars_sent % 32 == 0) fast_send = ($urandom_range(0, 3) == 0);
  endtask

  task automatic offer_text(input string s, input logic eot_on_last);
    for (int i = 0; i < s.len(); i++) begin
      offer_char(s[i], eot_on_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_letter();
    int n;
    n = $urandom_range(0, 51);
    return (n < 26) ? 8'(8'h61 + n) : 8'(8'h41 + n - 26);
  endfunction

  function automatic logic [7:0] pick_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9)) : pick_letter();
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Appends one token's worth of text, mostly well-formed, sometimes noise.
  function automatic void add_piece();
    string word;
    int    kind;
    int    n;
    logic  alnum_piece;
    kind = $urandom_range(0, 99);
    alnum_piece = 1'b0;
    if (kind < 20) begin
      word = kw_words[$urandom_range(0, 7)];
      case ($urandom_range(0, 5))
        0: word = {word, "x"};
        1: word[0] = word[0] - 8'd32;
        2: word = word.substr(0, word.len() - 2);
        default: ;
      endcase
      for (int i = 0; i < word.len(); i++) piece_q.push_back(word[i]);
      alnum_piece = 1'b1;
    end else if (kind < 38) begin
      n = $urandom_range(1, 8);
      piece_q.push_back(pick_letter());
      for (int i = 1; i < n; i++) piece_q.push_back(pick_alnum());
      alnum_piece = 1'b1;
    end else if (kind < 52) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) piece_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
      if ($urandom_range(0, 4) == 0) piece_q.push_back(pick_letter());
      alnum_piece = 1'b1;
    end else if (kind < 67) begin
      case ($urandom_range(0, 6))
        0: piece_q.push_back(CH_PLUS);
        1: piece_q.push_back(CH_MINUS);
        2: piece_q.push_back(CH_STAR);
        3: piece_q.push_back(CH_SLASH);
        4: piece_q.push_back(CH_LPAREN);
        5: piece_q.push_back(CH_RPAREN);
        default: piece_q.push_back(CH_SEMI);
      endcase
    end else if (kind < 75) begin
      piece_q.push_back(($urandom_range(0, 1) == 0) ? CH_EQUAL : CH_COLON);
      piece_q.push_back(CH_EQUAL);
    end else if (kind < 81) begin
      piece_q.push_back(($urandom_range(0, 1) == 0) ? CH_EQUAL : CH_COLON);
    end else if (kind < 94) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) piece_q.push_back(pick_separator());
    end else begin
      piece_q.push_back(8'($urandom_range(0, 255)));
    end
    if (alnum_piece && $urandom_range(0, 1) == 0) piece_q.push_back(pick_separator());
  endfunction

  // Receiver: draws a stall per beat; a long hold-off lets the scanner fill up.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        hold = LongHoldCycles;
        long_hold_req = 1'b0;
        long_holds++;
      end else begin
        hold = fast_recv ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tokens_taken++;
      if (tokens_taken % 32 == 0) fast_recv = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int         random_chars;
    int         waited;
    int         total_fails;
    logic       hold_asked;
    logic       drained;
    logic       long_done;
    logic [7:0] c;
    random_chars = 0;
    hold_asked   = 1'b0;
    drained      = 1'b0;
    long_done    = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every token class, lookahead pairs, lone '=' and ':', odd bytes, flush of a
    // pending '=' at end of text, and letters after a leading digit.
    offer_text("if (A9)==x:=-+*/;\t=\r: ", 1'b0);
    offer_char(8'h00, 1'b0);
    offer_char(8'hFF, 1'b0);
    offer_text("7e=", 1'b1);

    while (random_chars < RandomChars) begin
      if (!hold_asked && random_chars > 20) begin
        long_hold_req = 1'b1;
        hold_asked    = 1'b1;
      end
      if (!long_done && random_chars > 40) begin
        // One word past the length limit, ended by the end-of-text flag.
        piece_q.push_back(pick_letter());
        for (int i = 1; i < LongWordLen; i++) piece_q.push_back(pick_alnum());
        while (piece_q.size() > 0) begin
          c = piece_q.pop_front();
          offer_char(c, piece_q.size() == 0);
        end
        long_done = 1'b1;
      end
      if (!drained && random_chars > 75) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (outstanding != 0);
        drained = 1'b1;
      end
      add_piece();
      while (piece_q.size() > 0) begin
        c = piece_q.pop_front();
        offer_char(c, $urandom_range(0, 39) == 0);
        random_chars++;
      end
    end
    offer_char(CH_SEMI, 1'b1);
    in_valid_i <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (outstanding != 0 && waited < 4000);
    repeat (12) @(posedge clk_i);

    total_fails = chk_fails + outstanding;
    if (outstanding != 0) $display("%0d tokens never arrived", outstanding);
    $display("Scanned %0d characters and checked %0d tokens, with %0d long output hold-off(s)",
             chars_sent, tokens_checked, long_holds);
    $display("and a drain pause; %0d token mismatch(es) seen.", total_fails);
    if (total_fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Run timed out.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
rtl/tlex_pkg.sv
rtl/tlex_front.sv
rtl/tlex_queue.sv
rtl/tlex_back.sv
rtl/tiny_lexer_token_classifier_unit.sv
test/tlex_token_checker.sv
test/tb_tiny_lexer_token_classifier_unit.sv
